// ----- rtl/core/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// shared constants and types of the string literal escaper
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int MAX_RESULTS = 4;
	localparam int IDX_W       = $clog2(MAX_RESULTS);

	// request commands
	localparam logic [1:0] CMD_TALLY  = 2'd0;
	localparam logic [1:0] CMD_OPEN   = 2'd1;
	localparam logic [1:0] CMD_ESCAPE = 2'd2;
	localparam logic [1:0] CMD_CLOSE  = 2'd3;

	// characters
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_ESC    = 8'h1b;
	localparam logic [7:0] CH_DEL    = 8'h7f;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// output sequence of one request
	typedef struct packed {
		logic                        valid;
		logic [IDX_W-1:0]            last_idx;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} seq_t;

endpackage

// ----- rtl/core/string_literal_escaper.sv -----
// ----------------------------------------------------------------------------
// string_literal_escaper
// turns a byte string into a quoted, escaped literal
// ----------------------------------------------------------------------------
// input stream: s_tuser carries the command (tally, open, escape, close),
// s_tdata the string byte. output stream: the literal bytes on m_tdata,
// m_tlast marks the final byte caused by one input request. a request is
// registered on accept, encoded and loaded into the result register once
// that register is free. tally requests update the quote counters and give
// no output. each request leaves the input register as soon as the result
// register is free, so one request per cycle goes through while each
// yields at most one byte and the receiver is ready; an escape of n bytes
// (up to 4 for a hex escape) holds the result register until the one-byte
// output port has sent them all. a stalled receiver holds the current byte
// and backs up into the input register; tally requests still drain past a
// stalled output.
// reset clears both counters, selects the single quote and empties the path.
// ----------------------------------------------------------------------------
module string_literal_escaper import sle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic [1:0] s_tuser,   // command
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast    // last_of_run
);

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       out_free;
	seq_t       seq;

	assign advance  = valid_s1 && (cmd_s1 == CMD_TALLY || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	sle_encoder u_encoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.command (cmd_s1),
		.in_byte (byte_s1),
		.seq     (seq)
	);

	sle_out_buffer u_out_buffer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && seq.valid),
		.seq      (seq),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- rtl/core/sle_encoder.sv -----
// ----------------------------------------------------------------------------
// sle_encoder
// quote counters, quote choice and escape encoding of one request
// ----------------------------------------------------------------------------
module sle_encoder import sle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [1:0] command,
	input  logic [7:0] in_byte,
	output seq_t       seq
);

	logic [COUNT_WIDTH-1:0] single_q;
	logic [COUNT_WIDTH-1:0] double_q;
	logic                   quote_dbl_q;
	logic                   open_dbl;
	logic                   quote_dbl;
	logic [7:0]             qchar;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'h0, nib};
		end
		return 8'h57 + {4'h0, nib};
	endfunction

	assign open_dbl  = single_q > double_q;
	assign quote_dbl = (command == CMD_OPEN) ? open_dbl : quote_dbl_q;
	assign qchar     = quote_dbl ? CH_DQUOTE : CH_SQUOTE;

	always_comb begin
		seq          = '0;
		seq.valid    = 1'b1;
		seq.bytes[0] = CH_BSLASH;
		case (command)
			CMD_TALLY: begin
				seq.valid = 1'b0;
			end
			CMD_OPEN, CMD_CLOSE: begin
				seq.bytes[0] = qchar;
			end
			default: begin
				seq.last_idx = IDX_W'(1);
				case (in_byte)
					CH_BSLASH: seq.bytes[1] = CH_BSLASH;
					8'h07:     seq.bytes[1] = "a";
					8'h08:     seq.bytes[1] = "b";
					8'h0c:     seq.bytes[1] = "f";
					8'h0a:     seq.bytes[1] = "n";
					8'h0d:     seq.bytes[1] = "r";
					8'h09:     seq.bytes[1] = "t";
					8'h0b:     seq.bytes[1] = "v";
					CH_ESC:    seq.bytes[1] = "[";
					CH_SQUOTE, CH_DQUOTE: begin
						if (in_byte == qchar) begin
							seq.bytes[1] = in_byte;
						end else begin
							seq.last_idx = '0;
							seq.bytes[0] = in_byte;
						end
					end
					default: begin
						if (in_byte < CH_SPACE || in_byte == CH_DEL) begin
							seq.last_idx = IDX_W'(3);
							seq.bytes[1] = "x";
							seq.bytes[2] = hex_digit(in_byte[7:4]);
							seq.bytes[3] = hex_digit(in_byte[3:0]);
						end else begin
							seq.last_idx = '0;
							seq.bytes[0] = in_byte;
						end
					end
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q    <= '0;
			double_q    <= '0;
			quote_dbl_q <= 1'b0;
		end else if (fire) begin
			case (command)
				CMD_TALLY: begin
					if (in_byte == CH_SQUOTE && single_q != '1) begin
						single_q <= single_q + 1'b1;
					end
					if (in_byte == CH_DQUOTE && double_q != '1) begin
						double_q <= double_q + 1'b1;
					end
				end
				CMD_OPEN: begin
					quote_dbl_q <= open_dbl;
				end
				CMD_CLOSE: begin
					single_q <= '0;
					double_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/sle_out_buffer.sv -----
// ----------------------------------------------------------------------------
// sle_out_buffer
// result register holding one sequence and sending it one byte per cycle while the receiver is ready
// ----------------------------------------------------------------------------
module sle_out_buffer import sle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  seq_t       seq,
	output logic       free,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast    // last_of_run
);

	logic             valid_q;
	logic [IDX_W-1:0] idx_q;
	seq_t             seq_q;
	logic             at_last;

	assign at_last  = idx_q == seq_q.last_idx;
	assign free     = !valid_q || (m_tready && at_last);
	assign m_tvalid = valid_q;
	assign m_tdata  = seq_q.bytes[idx_q];
	assign m_tlast  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && m_tready) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seq_q <= seq;
		end
	end

endmodule

// ----- rtl/core/sle_checker.sv -----
// ----------------------------------------------------------------------------
// sle_checker
// port level checks of the string literal escaper
// ----------------------------------------------------------------------------
module sle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// stalled output holds its byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed under stall");

	// empty output never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output empty");

	// a run continues until its last byte
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("run broken before last byte");

	// output path is empty out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid out of reset");

endmodule

bind string_literal_escaper sle_checker u_sle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
